// ===== src/sha_pkg.sv =====
// SHA-256 stream hasher package: round constants, initial hash values,
// controller state type and controller/datapath command and status structs.
// No dependencies.
package sha_pkg;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_ROUNDS,
      ST_FINISH,
      ST_PAD_LEN,
      ST_OUTPUT
   } state_type;

   // what the compression was started for
   typedef enum logic [1:0] {
      GOAL_DATA,
      GOAL_PAD_EXTRA,
      GOAL_FINAL
   } goal_type;

   typedef struct packed {
      logic put_byte;       // store req byte at current position, count it
      logic put_pad;        // store 0x80 at current position (block already zero beyond)
      logic put_len;        // write bit length into words 14 and 15
      logic start_comp;     // load work regs from chain, round 0
      logic round;          // run one round
      logic fold;           // chain += work, clear block
      logic restart;        // return to initial state after digest
   } cmd_type;

   typedef struct packed {
      logic       block_full;   // byte position wraps to zero after this byte
      logic       last_round;   // round counter at 63
      logic [5:0] pos;          // next byte position
   } status_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ===== src/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher, top level.
// Input channel req_*: one word per message byte (req_has_byte), req_last ends
// the message; an empty last word hashes what was collected so far.
// Result channel rsp_*: one 256-bit digest as four big-endian 64-bit words,
// given once per message after the last word.
// A byte word is taken while req_stall is low. The 64th byte of a block starts a
// compression (one round per cycle) during which req_stall is high, so no
// further bytes are taken until it ends.
// After the last word: a padding step, a compression, and if the block had 56
// or more bytes a length step and another compression; then rsp_valid rises.
// A last word that fills a block adds its own compression before the padding.
// The digest holds while rsp_stall is high; intake resumes when it is taken,
// and the chaining state returns to the standard initial values.
// Reset (synchronous, high) clears counters, block buffer and work registers
// and loads the initial chain values; the block is ready in the next cycle.
// Depends on sha_pkg, sha_control, sha_datapath.
module sha256_stream_hasher_top import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_0,
   output logic [63:0] rsp_digest_1,
   output logic [63:0] rsp_digest_2,
   output logic [63:0] rsp_digest_3
);

   cmd_type      cmd;
   status_type   status;
   logic [255:0] digest;

   sha_control u_ctrl (
      .clock, .reset, .req_valid, .req_has_byte, .req_last,
      .req_stall, .rsp_valid, .rsp_stall, .status, .cmd
   );

   sha_datapath u_dp (
      .clock, .reset, .cmd, .data_byte(req_data_byte), .status, .digest
   );

   assign rsp_digest_0 = digest[255:192];
   assign rsp_digest_1 = digest[191:128];
   assign rsp_digest_2 = digest[127:64];
   assign rsp_digest_3 = digest[63:0];

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("accept while digest pending");

   a_digest_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_0)
      && $stable(rsp_digest_3)) else $error("digest changed under stall");

   a_full_block_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_has_byte && status.block_full |=> req_stall)
      else $error("full block did not start compression");

endmodule

// ===== src/sha_datapath.sv =====
// SHA-256 datapath: block buffer, rolling message schedule, round registers,
// chaining words and bit counter. Depends on sha_pkg.
module sha_datapath import sha_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  logic [7:0]   data_byte,
   output status_type   status,
   output logic [255:0] digest
);

   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [31:0] wrk_ff [8];
   logic [31:0] wrk_in [8];
   logic [31:0] chn_ff [8];
   logic [31:0] chn_in [8];
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  rnd_ff, rnd_in;

   logic [31:0] w15, w2, sg0, sg1, wnew, wv;
   logic [31:0] big0, big1, ch, maj, t1, t2;
   logic [7:0]  put_val;
   logic [3:0]  put_word;
   logic [1:0]  put_lane;

   // schedule kept as a 16-word shift window: blk[i] is W[t+i], wnew is W[t+16]
   assign w15  = blk_ff[1];
   assign w2   = blk_ff[14];
   assign sg0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
   assign sg1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
   assign wnew = blk_ff[0] + sg0 + blk_ff[9] + sg1;
   assign wv   = blk_ff[0];

   assign big1 = rotr(wrk_ff[4], 6) ^ rotr(wrk_ff[4], 11) ^ rotr(wrk_ff[4], 25);
   assign ch   = (wrk_ff[4] & wrk_ff[5]) ^ (~wrk_ff[4] & wrk_ff[6]);
   assign t1   = wrk_ff[7] + big1 + ch + ROUND_K[rnd_ff] + wv;
   assign big0 = rotr(wrk_ff[0], 2) ^ rotr(wrk_ff[0], 13) ^ rotr(wrk_ff[0], 22);
   assign maj  = (wrk_ff[0] & wrk_ff[1]) ^ (wrk_ff[0] & wrk_ff[2]) ^ (wrk_ff[1] & wrk_ff[2]);
   assign t2   = big0 + maj;

   assign put_val  = cmd.put_pad ? PAD_BYTE : data_byte;
   assign put_word = pos_ff[5:2];
   assign put_lane = pos_ff[1:0];

   always_comb begin
      blk_in  = blk_ff;
      wrk_in  = wrk_ff;
      chn_in  = chn_ff;
      pos_in  = pos_ff;
      bits_in = bits_ff;
      rnd_in  = rnd_ff;
      if (cmd.put_byte || cmd.put_pad) begin
         case (put_lane)
            2'd0:    blk_in[put_word][31:24] = put_val;
            2'd1:    blk_in[put_word][23:16] = put_val;
            2'd2:    blk_in[put_word][15:8]  = put_val;
            default: blk_in[put_word][7:0]   = put_val;
         endcase
      end
      if (cmd.put_byte) begin
         pos_in  = pos_ff + 6'd1;
         bits_in = bits_ff + 64'd8;
      end
      if (cmd.put_len) begin
         blk_in[14] = bits_ff[63:32];
         blk_in[15] = bits_ff[31:0];
      end
      if (cmd.start_comp) begin
         wrk_in = chn_ff;
         rnd_in = '0;
      end
      if (cmd.round) begin
         for (int i = 0; i < 15; i++) blk_in[i] = blk_ff[i + 1];
         blk_in[15] = wnew;
         for (int i = 7; i > 0; i--) wrk_in[i] = wrk_ff[i - 1];
         wrk_in[4] = wrk_ff[3] + t1;
         wrk_in[0] = t1 + t2;
         rnd_in = rnd_ff + 6'd1;
      end
      // fold comes with the last round, so it adds that round's result
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) chn_in[i] = chn_ff[i] + wrk_in[i];
         for (int i = 0; i < 16; i++) blk_in[i] = '0;
      end
      if (cmd.restart) begin
         chn_in  = INIT_H;
         pos_in  = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chn_ff  <= INIT_H;
         pos_ff  <= '0;
         bits_ff <= '0;
         rnd_ff  <= '0;
         for (int i = 0; i < 16; i++) blk_ff[i] <= '0;
         for (int i = 0; i < 8; i++) wrk_ff[i] <= '0;
      end else begin
         chn_ff  <= chn_in;
         pos_ff  <= pos_in;
         bits_ff <= bits_in;
         rnd_ff  <= rnd_in;
         blk_ff  <= blk_in;
         wrk_ff  <= wrk_in;
      end
   end

   assign status.block_full = cmd.put_byte && (pos_ff == 6'd63);
   assign status.last_round = (rnd_ff == 6'd63);
   assign status.pos        = pos_ff;
   assign digest = {chn_ff[0], chn_ff[1], chn_ff[2], chn_ff[3],
                    chn_ff[4], chn_ff[5], chn_ff[6], chn_ff[7]};

endmodule

// ===== src/sha_control.sv =====
// SHA-256 controller: sequences byte intake, compressions, padding and
// digest hand-off. Depends on sha_pkg.
module sha_control import sha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_has_byte,
   input  logic       req_last,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   goal_type  goal_ff, goal_in;
   logic      last_ff, last_in;   // message end pending behind a data compression
   logic      acc;

   assign acc = (state_ff == ST_COLLECT) && req_valid;

   always_comb begin
      state_in = state_ff;
      goal_in  = goal_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               if (req_has_byte && status.pos == 6'd63) begin
                  state_in = ST_ROUNDS;
                  goal_in  = GOAL_DATA;
                  last_in  = req_last;
               end else if (req_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_ROUNDS: begin
            if (status.last_round) begin
               case (goal_ff)
                  GOAL_DATA:      state_in = last_ff ? ST_FINISH : ST_COLLECT;
                  GOAL_PAD_EXTRA: state_in = ST_PAD_LEN;
                  default:        state_in = ST_OUTPUT;
               endcase
            end
         end
         ST_FINISH: begin
            state_in = ST_ROUNDS;
            last_in  = 1'b0;
            goal_in  = (status.pos >= 6'd56) ? GOAL_PAD_EXTRA : GOAL_FINAL;
         end
         ST_PAD_LEN: begin
            state_in = ST_ROUNDS;
            goal_in  = GOAL_FINAL;
         end
         ST_OUTPUT: begin
            if (!rsp_stall) state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_stall  = (state_ff != ST_COLLECT);
      rsp_valid  = (state_ff == ST_OUTPUT);
      case (state_ff)
         ST_COLLECT: begin
            cmd.put_byte   = acc && req_has_byte;
            cmd.start_comp = acc && req_has_byte && status.pos == 6'd63;
         end
         ST_ROUNDS: begin
            cmd.round = 1'b1;
            cmd.fold  = status.last_round;
         end
         ST_FINISH: begin
            cmd.put_pad    = 1'b1;
            cmd.put_len    = (status.pos < 6'd56);
            cmd.start_comp = 1'b1;
         end
         ST_PAD_LEN: begin
            cmd.put_len    = 1'b1;
            cmd.start_comp = 1'b1;
         end
         ST_OUTPUT: begin
            cmd.restart = !rsp_stall;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         goal_ff  <= GOAL_DATA;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         goal_ff  <= goal_in;
         last_ff  <= last_in;
      end
   end

endmodule
